// ===== hdl/sri_pkg.sv =====
`timescale 1ns / 1ps

package sri_pkg;

  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 32;
  localparam int RPM_W   = 17;
  localparam int RATIO_W = 17;
  localparam int DIV_CNT_W = 5;

  localparam logic [RATIO_W-1:0]   RATIO_MAX = 17'h1FFFF;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_BIT = 5'd16;

  // 2*pi/60 in Q0.31, rounded.
  localparam logic [27:0] RPM_TO_RADS_Q31 = 28'd224883962;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        [TIME_W-1:0]  time_ms;
    logic signed [LEVEL_W-1:0] level;
    logic signed [RPM_W-1:0]   rpm;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v[63:31] == {33{v[63]}}) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== hdl/sri_item_if.sv =====
`timescale 1ns / 1ps

interface sri_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  entry_index;
  logic [31:0] entry_time_ms;
  logic signed [31:0] entry_level;
  logic signed [16:0] entry_rpm;
  logic [31:0] now_ms;

  modport source (
    output valid, cmd, entry_index, entry_time_ms, entry_level, entry_rpm, now_ms,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_index, entry_time_ms, entry_level, entry_rpm, now_ms,
    output ready
  );
endinterface

// ===== hdl/sri_result_if.sv =====
`timescale 1ns / 1ps

interface sri_result_if;
  logic        valid;
  logic        ready;
  logic        complete;
  logic signed [31:0] level_setpoint;
  logic signed [31:0] speed_rps;

  modport source (
    output valid, complete, level_setpoint, speed_rps,
    input  ready
  );

  modport sink (
    input  valid, complete, level_setpoint, speed_rps,
    output ready
  );
endinterface

// ===== hdl/sri_ram.sv =====
`timescale 1ns / 1ps

module sri_ram #(
  parameter int WIDTH = 81,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/startup_ramp_interpolator_top.sv =====
// Start-up ramp interpolator. A load beat (cmd 0) writes one breakpoint of
// time, Q1.31 level and rpm into the table, restarts the profile at the
// first segment and yields no result. A tick beat (cmd 1) yields one
// result: when the time elapsed since start_time_ms has reached the last
// breakpoint the held level and speed are repeated, otherwise the level and
// the speed in Q16.16 rad/s are interpolated within the current segment.
// The pace of that interpolation is set by the 17-step shift-subtract
// divider for the segment ratio, the one 19 by 34 bit multiplier used four
// times in turn and the single read port of the breakpoint table; when the
// ratio is zero or saturates the divider is skipped. The block takes no new
// beat until the current tick has been handed to the output register.
`timescale 1ns / 1ps

module startup_ramp_interpolator_top #(
  parameter int ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  sri_item_if.sink           item,
  sri_result_if.source       result
);

  localparam int IW = $clog2(ENTRIES);
  localparam int AW = (IW > 3) ? IW : 3;
  localparam logic [IW-1:0] LAST_ADDR = IW'(ENTRIES - 1);
  localparam logic [IW-1:0] LAST_SEG  = IW'(ENTRIES - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_T0, S_T1, S_PREP, S_DIV, S_MUL_L, S_MUL_R,
    S_SUM_R, S_MUL_H, S_MUL_L2, S_ACC, S_OUT
  } state_t;

  state_t state;

  logic [31:0]        start_time_ms;
  logic [IW-1:0]      seg;
  logic signed [31:0] held_level;
  logic signed [31:0] held_speed;

  logic [31:0]        elapsed;
  logic               comp;
  logic [31:0]        t0;
  logic signed [31:0] l0;
  logic signed [16:0] r0;
  logic [31:0]        dlt;
  logic               early;
  logic [31:0]        den;
  logic               zero_ratio;
  logic               adv;
  logic signed [32:0] ldiff;
  logic signed [17:0] rdiff;
  logic [sri_pkg::RATIO_W-1:0]   ratio;
  logic [31:0]                   rem;
  logic                          nbit;
  logic [sri_pkg::DIV_CNT_W-1:0] cnt;
  logic signed [52:0] prod;
  logic signed [35:0] rq;
  logic signed [63:0] acc;

  logic [AW-1:0]               idx_ext;
  logic                        wr_en;
  sri_pkg::entry_t             wr_entry;
  logic [sri_pkg::ENTRY_W-1:0] rd_data;
  sri_pkg::entry_t             rd_entry;
  logic [IW-1:0]               rd_addr;

  logic signed [18:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [52:0] prod_sh;
  logic signed [35:0] lvl_sum;
  logic signed [63:0] prod_ext;
  logic signed [63:0] total;
  logic [33:0]        div_diff;
  logic               accept;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  assign idx_ext  = AW'(item.entry_index);
  assign wr_en    = accept && (item.cmd == sri_pkg::CMD_LOAD)
                    && ({1'b0, idx_ext} < (AW + 1)'(ENTRIES));
  assign wr_entry = '{time_ms: item.entry_time_ms, level: item.entry_level,
                      rpm: item.entry_rpm};
  assign rd_entry = sri_pkg::entry_t'(rd_data);

  always_comb begin
    case (state)
      S_LAST:  rd_addr = seg;
      S_T0:    rd_addr = seg + 1'b1;
      default: rd_addr = LAST_ADDR;
    endcase
  end

  sri_ram #(
    .WIDTH (sri_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[IW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    case (state)
      S_MUL_L: begin
        mul_a = {2'b00, ratio};
        mul_b = {ldiff[32], ldiff};
      end
      S_MUL_R: begin
        mul_a = {2'b00, ratio};
        mul_b = {{16{rdiff[17]}}, rdiff};
      end
      S_MUL_H: begin
        mul_a = rq[35:17];
        mul_b = {6'b000000, sri_pkg::RPM_TO_RADS_Q31};
      end
      S_MUL_L2: begin
        mul_a = {2'b00, rq[16:0]};
        mul_b = {6'b000000, sri_pkg::RPM_TO_RADS_Q31};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_sh  = prod >>> 16;
  assign lvl_sum  = {{4{l0[31]}}, l0} + prod_sh[35:0];
  assign prod_ext = {{11{prod[52]}}, prod};
  assign total    = acc + prod_ext;
  assign div_diff = {1'b0, rem, nbit} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      start_time_ms <= '0;
      seg           <= '0;
      held_level    <= '0;
      held_speed    <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_time_ms <= cfg_wr_data;
      end
      if (result.valid && result.ready && (state != S_OUT)) begin
        result.valid <= 1'b0;
      end
      prod <= mul_a * mul_b;

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.cmd == sri_pkg::CMD_LOAD) begin
              seg <= '0;
            end else begin
              elapsed <= item.now_ms - start_time_ms;
              state   <= S_LAST;
            end
          end
        end
        S_LAST: begin
          comp <= (elapsed >= rd_entry.time_ms);
          if (elapsed >= rd_entry.time_ms) begin
            state <= S_OUT;
          end else begin
            state <= S_T0;
          end
        end
        S_T0: begin
          t0     <= rd_entry.time_ms;
          l0     <= rd_entry.level;
          r0     <= rd_entry.rpm;
          dlt    <= elapsed - rd_entry.time_ms;
          early  <= (elapsed <= rd_entry.time_ms);
          state  <= S_T1;
        end
        S_T1: begin
          den        <= rd_entry.time_ms - t0;
          zero_ratio <= early || (rd_entry.time_ms <= t0);
          adv        <= (seg < LAST_SEG) && (elapsed > rd_entry.time_ms);
          ldiff      <= {rd_entry.level[31], rd_entry.level} - {l0[31], l0};
          rdiff      <= {rd_entry.rpm[16], rd_entry.rpm} - {r0[16], r0};
          state      <= S_PREP;
        end
        S_PREP: begin
          if (zero_ratio) begin
            ratio <= '0;
            state <= S_MUL_L;
          end else if ({1'b0, dlt} >= {den, 1'b0}) begin
            ratio <= sri_pkg::RATIO_MAX;
            state <= S_MUL_L;
          end else begin
            ratio <= '0;
            rem   <= {1'b0, dlt[31:1]};
            nbit  <= dlt[0];
            cnt   <= sri_pkg::DIV_LAST_BIT;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_diff[33]) begin
            rem <= div_diff[31:0];
          end else begin
            rem <= {rem[30:0], nbit};
          end
          ratio <= {ratio[sri_pkg::RATIO_W-2:0], ~div_diff[33]};
          nbit  <= 1'b0;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_MUL_L;
          end
        end
        S_MUL_L: begin
          state <= S_MUL_R;
        end
        S_MUL_R: begin
          held_level <= sri_pkg::sat32({{28{lvl_sum[35]}}, lvl_sum});
          state      <= S_SUM_R;
        end
        S_SUM_R: begin
          rq    <= {{3{r0[16]}}, r0, 16'h0000} + prod[35:0];
          state <= S_MUL_H;
        end
        S_MUL_H: begin
          state <= S_MUL_L2;
        end
        S_MUL_L2: begin
          acc   <= prod_ext <<< 17;
          state <= S_ACC;
        end
        S_ACC: begin
          held_speed <= sri_pkg::sat32(total >>> 31);
          if (adv) begin
            seg <= seg + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.complete       <= comp;
            result.level_setpoint <= held_level;
            result.speed_rps      <= held_speed;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The segment never runs past the last pair of breakpoints.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    seg <= LAST_SEG)
    else $error("segment index beyond the last segment");

  // A load beat restarts the profile at the first segment.
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.cmd == sri_pkg::CMD_LOAD) |=> (seg == '0))
    else $error("load beat did not clear the segment index");

  // The divider's partial remainder stays below the segment length.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  // A result appears only when the sequencer hands one over.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == S_OUT))
    else $error("result beat raised outside the output step");
`endif

endmodule

// ===== bench/startup_ramp_interpolator_top_test.sv =====
`timescale 1ns / 1ps

module startup_ramp_interpolator_top_test;

  localparam int ENTRIES = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam longint RATIO_CEIL = 131071;
  localparam longint RAD_PER_RPM_Q31 = 224883962;
  localparam longint Q31_MAX = 64'sh7FFF_FFFF;
  localparam longint Q31_MIN = -64'sh8000_0000;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         index;
    logic [31:0]        t_ms;
    logic signed [31:0] level;
    logic signed [16:0] rpm;
    logic [31:0]        now;
  } ramp_beat_t;

  typedef struct packed {
    logic               complete;
    logic signed [31:0] level;
    logic signed [31:0] speed;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  sri_item_if item_bus ();
  sri_result_if result_bus ();

  startup_ramp_interpolator_top #(
    .ENTRIES(ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .item(item_bus),
    .result(result_bus)
  );

  always #1 clk = ~clk;

  // Own copy of the profile state, updated as beats are accepted.
  logic [31:0]        bp_time [ENTRIES];
  logic signed [31:0] bp_level [ENTRIES];
  logic signed [16:0] bp_rpm [ENTRIES];
  int unsigned        seg_now = 0;
  logic signed [31:0] held_level = '0;
  logic signed [31:0] held_speed = '0;
  logic [31:0]        start_ms = '0;

  ramp_beat_t  beats_to_send[$];
  setpoint_t   setpoints_due[$];
  ramp_beat_t  next_beat;
  setpoint_t   want;
  setpoint_t   got;
  bit          in_fired = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned beats_queued = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  logic [31:0] start_now = '0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > Q31_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < Q31_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic setpoint_t ramp_setpoint(input logic [31:0] now);
    setpoint_t   sp;
    logic [31:0] elapsed;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] offset;
    logic [31:0] span;
    int unsigned seg;
    longint      quot;
    longint      ratio;
    longint      lvl;
    longint      rq16;
    elapsed = now - start_ms;
    sp.complete = (elapsed >= bp_time[ENTRIES-1]);
    if (!sp.complete) begin
      seg = (seg_now > ENTRIES - 2) ? ENTRIES - 2 : seg_now;
      t0 = bp_time[seg];
      t1 = bp_time[seg+1];
      if (t1 <= t0 || elapsed <= t0) begin
        ratio = 0;
      end else begin
        offset = elapsed - t0;
        span = t1 - t0;
        quot = (longint'(offset) << 16) / longint'(span);
        ratio = (quot > RATIO_CEIL) ? RATIO_CEIL : quot;
      end
      lvl = longint'(bp_level[seg]) +
            ((ratio * (longint'(bp_level[seg+1]) - longint'(bp_level[seg]))) >>> 16);
      held_level = clamp32(lvl);
      rq16 = longint'(bp_rpm[seg]) * 65536 +
             ratio * (longint'(bp_rpm[seg+1]) - longint'(bp_rpm[seg]));
      held_speed = clamp32((rq16 * RAD_PER_RPM_Q31) >>> 31);
      if (seg < ENTRIES - 2 && elapsed > t1) begin
        seg++;
      end
      seg_now = seg;
    end
    sp.level = held_level;
    sp.speed = held_speed;
    return sp;
  endfunction

  // Prediction and checking, both on accepted beats.
  always @(posedge clk) begin
    in_fired = item_bus.valid && item_bus.ready;
    if (!rst) begin
      if (cfg_wr_en) begin
        start_ms = cfg_wr_data;
      end
      if (result_bus.valid && result_bus.ready) begin
        got.complete = result_bus.complete;
        got.level = result_bus.level_setpoint;
        got.speed = result_bus.speed_rps;
        if (setpoints_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result complete=%0b level=%0d speed=%0d",
                   $time, got.complete, got.level, got.speed);
        end else begin
          want = setpoints_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected complete=%0b level=%0d speed=%0d, got %0b %0d %0d",
                     $time, want.complete, want.level, want.speed,
                     got.complete, got.level, got.speed);
          end
        end
      end
      if (in_fired) begin
        if (item_bus.cmd == sri_pkg::CMD_LOAD) begin
          bp_time[item_bus.entry_index] = item_bus.entry_time_ms;
          bp_level[item_bus.entry_index] = item_bus.entry_level;
          bp_rpm[item_bus.entry_index] = item_bus.entry_rpm;
          seg_now = 0;
        end else begin
          setpoints_due.push_back(ramp_setpoint(item_bus.now_ms));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || in_fired) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        item_bus.valid <= 1'b1;
        item_bus.cmd <= next_beat.cmd;
        item_bus.entry_index <= next_beat.index;
        item_bus.entry_time_ms <= next_beat.t_ms;
        item_bus.entry_level <= next_beat.level;
        item_bus.entry_rpm <= next_beat.rpm;
        item_bus.now_ms <= next_beat.now;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  always @(negedge clk) begin
    result_bus.ready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_load(input logic [2:0] idx, input logic [31:0] t_ms,
                           input logic [31:0] lvl, input logic [16:0] rpm);
    ramp_beat_t b;
    b.cmd = sri_pkg::CMD_LOAD;
    b.index = idx;
    b.t_ms = t_ms;
    b.level = lvl;
    b.rpm = rpm;
    b.now = $urandom();
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  task automatic push_tick(input logic [31:0] now);
    ramp_beat_t b;
    b.cmd = sri_pkg::CMD_TICK;
    b.index = 3'($urandom_range(7));
    b.t_ms = $urandom();
    b.level = $urandom();
    b.rpm = 17'($urandom_range(0, 17'h1FFFF));
    b.now = now;
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [16:0] pick_rpm();
    case ($urandom_range(7))
      0: return 17'h0FFFF;
      1: return 17'h10000;
      default: return 17'($urandom_range(0, 17'h1FFFF));
    endcase
  endfunction

  // A full table load followed by ticks that sweep through the segments.
  task automatic push_profile();
    logic [31:0] bp [ENTRIES];
    logic [31:0] elapsed;
    int unsigned step_max;
    int unsigned ticks;
    int k;
    bp[0] = ($urandom_range(1) == 1) ? $urandom_range(0, 32'hFFFF_0000) : $urandom_range(0, 500);
    for (k = 1; k < ENTRIES; k++) begin
      case ($urandom_range(19))
        0: bp[k] = bp[k-1];
        1: bp[k] = (bp[k-1] > 50) ? bp[k-1] - $urandom_range(1, 50) : bp[k-1];
        default: bp[k] = bp[k-1] + $urandom_range(1, 600);
      endcase
    end
    for (k = 0; k < ENTRIES; k++) begin
      push_load(3'(k), bp[k], pick_level(), pick_rpm());
    end
    step_max = ($urandom_range(1) == 1) ? 60 : 400;
    elapsed = (bp[0] > 40) ? bp[0] - $urandom_range(0, 40) : 32'd0;
    ticks = 0;
    while (elapsed < bp[ENTRIES-1] && ticks < 40) begin
      push_tick(start_now + elapsed);
      elapsed += $urandom_range(0, step_max);
      ticks++;
    end
    repeat ($urandom_range(1, 2)) begin
      push_tick(start_now + elapsed);
      elapsed += $urandom_range(0, step_max);
    end
  endtask

  task automatic push_noise();
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(2))
        0: push_load(3'($urandom_range(7)), $urandom(), $urandom(),
                     17'($urandom_range(0, 17'h1FFFF)));
        1: push_tick($urandom());
        default: push_tick(start_now + $urandom_range(0, 5000));
      endcase
    end
  endtask

  task automatic set_start(input logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    start_now = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every beat is taken and every result is back; a load may
  // still be in flight, hence the extra cycles.
  task automatic settle();
    do begin
      @(posedge clk);
    end while (beats_to_send.size() != 0 || item_bus.valid || setpoints_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] start, input int unsigned idle_in,
                           input int unsigned stall_out, input bit long_hold,
                           input int unsigned n);
    int unsigned goal;
    set_start(start);
    @(posedge clk);
    send_idle_pct = idle_in;
    recv_stall_pct = stall_out;
    if (long_hold) begin
      hold_asked++;
    end
    goal = beats_queued + n;
    while (beats_queued < goal) begin
      if ($urandom_range(4) == 0) begin
        push_noise();
      end else begin
        push_profile();
      end
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    item_bus.valid = 1'b0;
    item_bus.cmd = sri_pkg::CMD_LOAD;
    item_bus.entry_index = '0;
    item_bus.entry_time_ms = '0;
    item_bus.entry_level = '0;
    item_bus.entry_rpm = '0;
    item_bus.now_ms = '0;
    result_bus.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Breakpoints with a zero-length segment, a decreasing segment and
    // full-scale levels and speeds.
    set_start(32'd0);
    push_load(3'd0, 32'd0, 32'h7FFF_FFFF, 17'h10000);
    push_load(3'd1, 32'd100, 32'h8000_0000, 17'h0FFFF);
    push_load(3'd2, 32'd100, 32'h0000_0000, 17'h10000);
    push_load(3'd3, 32'd50, 32'h4000_0000, 17'h00000);
    push_load(3'd4, 32'd300, 32'hC000_0000, 17'h0FFFF);
    push_load(3'd5, 32'd400, 32'h7FFF_FFFF, 17'h10000);
    push_load(3'd6, 32'd1000, 32'h8000_0000, 17'h00123);
    push_load(3'd7, 32'd2000, 32'h1234_5678, 17'h1FFFF);
    push_tick(32'd0);
    push_tick(32'd50);
    push_tick(32'd250);
    push_tick(32'd250);
    push_tick(32'd250);
    push_tick(32'd120);
    push_tick(32'd350);
    push_tick(32'd390);
    push_tick(32'd900);
    push_tick(32'd1500);
    push_tick(32'd1999);
    push_tick(32'd2000);
    push_tick(32'hFFFF_FFFF);
    push_load(3'd0, 32'd500, 32'h0000_0001, 17'h00001);
    push_tick(32'd200);
    settle();

    run_phase(32'hFFFF_FFFF, 0, 0, 1'b0, 300);
    run_phase($urandom(), 63, 0, 1'b0, 310);
    run_phase($urandom(), 0, 63, 1'b1, 310);
    run_phase(32'd0, 32, 32, 1'b1, 310);
    run_phase($urandom_range(0, 1000), 0, 0, 1'b0, 300);

    if (errors == 0 && setpoints_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
